### hw/rtl/rqsk_pkg.sv
`default_nettype none
package rqsk_pkg;

    localparam int REC_DEPTH = 1024;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int STK_DEPTH = 1024;
    localparam int SP_W      = 11;

    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
    } rec_t;

    typedef struct packed {
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
    } range_t;

    localparam int REC_W = $bits(rec_t);
    localparam int RNG_W = $bits(range_t);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_RANGE,
        ST_PIV,
        ST_NEXT,
        ST_JD,
        ST_ID,
        ST_WJ,
        ST_FI,
        ST_FP,
        ST_PUSH_R,
        ST_PUSH_L,
        ST_POP,
        ST_POPD
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/rqsk_ram.sv
`default_nettype none
module rqsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/record_quicksort_by_key.sv
`default_nettype none
// Channel | Dir | tdata fields (low bit first)                         | tuser          | tlast
// s_      | in  | sort_key[31:0], payload_tag[63:32], read_index[73:64]  | action         | last_record
// m_      | out | out_key[31:0], arrival_position[41:32],                | index_invalid  | -
//         |     | out_payload[73:42], record_count[84:74]                |                |
//
// A load beat is written on accept; the input stays ready unless the beat starts a
// sort. A read beat passes accept, a registered memory read and the output register.
// A last_record load that leaves at least two records starts an in-place Lomuto
// sort in the record memory. A kept element is read and compared; a swapped one
// also reads record i and writes records j and i back through the write port.
// Reset clears the control state only; memories need no clearing pass.
// A pending result stalls input until m_tready takes it.
module record_quicksort_by_key
    import rqsk_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,  // sort_key, payload_tag, read_index, zero pad
    input  wire logic        s_tuser,  // action
    input  wire logic        s_tlast,  // last_record
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [87:0] m_tdata,  // out_key, arrival_position, out_payload,
                                       // record_count, zero pad
    output logic             m_tuser   // index_invalid
);

    // input field unpack
    logic [KEY_W-1:0] in_key;
    logic [PAY_W-1:0] in_pay;
    logic [IDX_W-1:0] in_idx;
    assign in_key = s_tdata[KEY_W-1:0];
    assign in_pay = s_tdata[KEY_W+PAY_W-1:KEY_W];
    assign in_idx = s_tdata[KEY_W+PAY_W+IDX_W-1:KEY_W+PAY_W];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] loaded_count_reg, loaded_count_next;
    logic             batch_done_reg, batch_done_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    rec_t             piv_reg, piv_next, recj_reg, recj_next, reci_reg, reci_next;
    logic             inv_reg, inv_next;
    logic [CNT_W-1:0] cnt_out_reg, cnt_out_next;
    logic             m_valid_reg, m_valid_next;
    rec_t             m_rec_reg, m_rec_next;
    logic             m_inv_reg, m_inv_next;
    logic [CNT_W-1:0] m_cnt_reg, m_cnt_next;

    // record memory
    logic             rec_we;
    logic [IDX_W-1:0] rec_waddr, rec_raddr;
    rec_t             rec_wdata, rec_rdata;
    logic [REC_W-1:0] rec_rbits;
    assign rec_rdata = rec_t'(rec_rbits);

    rqsk_ram #(.WIDTH(REC_W), .DEPTH(REC_DEPTH)) u_rec_ram (
        .aclk  (aclk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (rec_raddr),
        .rdata (rec_rbits)
    );

    // range stack memory
    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr, stk_raddr;
    range_t           stk_wdata, stk_rdata;
    logic [RNG_W-1:0] stk_rbits;
    assign stk_rdata = range_t'(stk_rbits);

    rqsk_ram #(.WIDTH(RNG_W), .DEPTH(STK_DEPTH)) u_stk_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rbits)
    );

    logic             s_fire;
    logic [CNT_W-1:0] eff_count;   // count as a new load sees it
    logic [CNT_W-1:0] read_count;  // count as a read sees it
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] i_plus1, lo_plus2;
    logic             key_le;
    logic [SP_W-1:0]  sp_mid;

    assign s_tready   = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire     = s_tvalid && s_tready;
    assign eff_count  = batch_done_reg ? '0 : loaded_count_reg;
    assign read_count = batch_done_reg ? loaded_count_reg : '0;
    assign cnt_inc    = eff_count + CNT_W'(1);
    assign i_plus1    = {1'b0, i_reg} + CNT_W'(1);
    assign lo_plus2   = {1'b0, lo_reg} + CNT_W'(2);
    assign key_le     = $signed(rec_rdata.key) <= $signed(piv_reg.key);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            loaded_count_reg <= '0;
            batch_done_reg   <= 1'b0;
            sp_reg           <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            batch_done_reg   <= batch_done_next;
            sp_reg           <= sp_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        piv_reg     <= piv_next;
        recj_reg    <= recj_next;
        reci_reg    <= reci_next;
        inv_reg     <= inv_next;
        cnt_out_reg <= cnt_out_next;
        m_rec_reg   <= m_rec_next;
        m_inv_reg   <= m_inv_next;
        m_cnt_reg   <= m_cnt_next;
    end

    always_comb begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        batch_done_next   = batch_done_reg;
        sp_next           = sp_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        piv_next          = piv_reg;
        recj_next         = recj_reg;
        reci_next         = reci_reg;
        inv_next          = inv_reg;
        cnt_out_next      = cnt_out_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        m_rec_next        = m_rec_reg;
        m_inv_next        = m_inv_reg;
        m_cnt_next        = m_cnt_reg;
        rec_we            = 1'b0;
        rec_waddr         = i_reg;
        rec_wdata         = recj_reg;
        rec_raddr         = j_reg;
        stk_we            = 1'b0;
        stk_waddr         = sp_reg[IDX_W-1:0];
        stk_wdata         = '{hi: hi_reg, lo: i_plus1[IDX_W-1:0]};
        stk_raddr         = sp_reg[IDX_W-1:0];
        sp_mid            = sp_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == ACT_LOAD) begin
                    // a load after a finished batch opens a new one
                    batch_done_next   = 1'b0;
                    loaded_count_next = eff_count;
                    if (eff_count < CNT_W'(REC_DEPTH)) begin
                        rec_we            = 1'b1;
                        rec_waddr         = eff_count[IDX_W-1:0];
                        rec_wdata         = '{pos: eff_count[IDX_W-1:0],
                                              payload: in_pay, key: in_key};
                        loaded_count_next = cnt_inc;
                    end
                    if (s_tlast) begin
                        batch_done_next = 1'b1;
                        if (loaded_count_next >= CNT_W'(2)) begin
                            lo_next    = '0;
                            hi_next    = IDX_W'(loaded_count_next - CNT_W'(1));
                            sp_next    = '0;
                            state_next = ST_RANGE;
                        end
                    end
                end else if (s_fire) begin
                    rec_raddr    = in_idx;
                    inv_next     = {1'b0, in_idx} >= read_count;
                    cnt_out_next = read_count;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_rec_next   = inv_reg ? '0 : rec_rdata;
                m_inv_next   = inv_reg;
                m_cnt_next   = cnt_out_reg;
                state_next   = ST_IDLE;
            end
            ST_RANGE: begin
                rec_raddr  = hi_reg;
                state_next = ST_PIV;
            end
            ST_PIV: begin
                piv_next   = rec_rdata;
                i_next     = lo_reg;
                j_next     = lo_reg;
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                if (j_reg < hi_reg) begin
                    rec_raddr  = j_reg;
                    state_next = ST_JD;
                end else begin
                    rec_raddr  = i_reg;
                    state_next = ST_FI;
                end
            end
            ST_JD: begin
                recj_next = rec_rdata;
                if (key_le && i_reg != j_reg) begin
                    rec_raddr  = i_reg;
                    state_next = ST_ID;
                end else begin
                    if (key_le) begin
                        i_next = i_reg + IDX_W'(1);
                    end
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_NEXT;
                end
            end
            ST_ID: begin
                // swap: record j goes to i now, record i to j next cycle
                reci_next  = rec_rdata;
                rec_we     = 1'b1;
                rec_waddr  = i_reg;
                rec_wdata  = recj_reg;
                state_next = ST_WJ;
            end
            ST_WJ: begin
                rec_we     = 1'b1;
                rec_waddr  = j_reg;
                rec_wdata  = reci_reg;
                i_next     = i_reg + IDX_W'(1);
                j_next     = j_reg + IDX_W'(1);
                state_next = ST_NEXT;
            end
            ST_FI: begin
                rec_we     = 1'b1;
                rec_waddr  = hi_reg;
                rec_wdata  = rec_rdata;
                state_next = ST_FP;
            end
            ST_FP: begin
                rec_we     = 1'b1;
                rec_waddr  = i_reg;
                rec_wdata  = piv_reg;
                state_next = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                if (i_plus1 < {1'b0, hi_reg} && sp_reg < SP_W'(STK_DEPTH)) begin
                    stk_we  = 1'b1;
                    stk_wdata = '{hi: hi_reg, lo: i_plus1[IDX_W-1:0]};
                    sp_next = sp_reg + SP_W'(1);
                end
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                if ({1'b0, i_reg} >= lo_plus2 && sp_reg < SP_W'(STK_DEPTH)) begin
                    stk_we    = 1'b1;
                    stk_wdata = '{hi: i_reg - IDX_W'(1), lo: lo_reg};
                    sp_mid    = sp_reg + SP_W'(1);
                end
                sp_next    = sp_mid;
                state_next = (sp_mid != '0) ? ST_POP : ST_IDLE;
            end
            ST_POP: begin
                sp_next    = sp_reg - SP_W'(1);
                stk_raddr  = IDX_W'(sp_reg - SP_W'(1));
                state_next = ST_POPD;
            end
            ST_POPD: begin
                lo_next    = stk_rdata.lo;
                hi_next    = stk_rdata.hi;
                rec_raddr  = stk_rdata.hi;
                state_next = ST_PIV;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_inv_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_rec_reg.payload, m_rec_reg.pos, m_rec_reg.key};

`ifndef SYNTHESIS
    a_out_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_READ))
        else $error("result raised without a memory read");

    a_partition_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NEXT) |-> (i_reg <= j_reg && j_reg <= hi_reg && lo_reg <= i_reg))
        else $error("partition indexes out of order");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(STK_DEPTH))
        else $error("range stack overflow");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_inv_reg) |-> (m_rec_reg == '0))
        else $error("invalid read carries data");

    a_sort_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PIV) |-> batch_done_reg)
        else $error("sort running outside a closed batch");
`endif

endmodule
`default_nettype wire
